// ----- hw/rtl/ftcs_pkg.sv -----
// shared constants and beat types for the flat triangle column span raster
// no dependencies
package ftcs_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 200;

	localparam int COORD_W   = 12;
	localparam int COLOR_W   = 16;
	localparam int FRAC_W    = 16;
	localparam int COL_W     = $clog2(SCREEN_WIDTH);
	localparam int ROW_W     = $clog2(SCREEN_HEIGHT + 1);
	localparam int ACC_W     = ROW_W + FRAC_W;
	localparam int OUT_COL_W = 9;
	localparam int OUT_ROW_W = 8;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                      kind;
		logic signed [COORD_W-1:0]  ax;
		logic signed [COORD_W-1:0]  ay;
		logic signed [COORD_W-1:0]  bx;
		logic signed [COORD_W-1:0]  by;
		logic signed [COORD_W-1:0]  cx;
		logic signed [COORD_W-1:0]  cy;
		logic        [COLOR_W-1:0]  color;
	} in_beat_t;

	typedef struct packed {
		logic [OUT_COL_W-1:0] column;
		logic [OUT_ROW_W-1:0] top_row;
		logic [OUT_ROW_W-1:0] bottom_row;
		logic [COLOR_W-1:0]   fill_value;
		logic                 empty_res;
		logic                 last;
	} out_beat_t;

	typedef struct packed {
		logic             start;
		logic             neg;
		logic [ACC_W-1:0] dividend;
		logic [COL_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [ACC_W:0]   quotient;
	} div_rsp_t;

endpackage

// ----- hw/rtl/ftcs_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module ftcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/ftcs_div.sv -----
// radix-2 restoring divider for the edge slope, one quotient bit per cycle
// depends on ftcs_pkg
module ftcs_div
	import ftcs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(ACC_W + 1);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [COL_W:0]   rem_q;
	logic [ACC_W-1:0] quo_q;
	logic [COL_W-1:0] dsr_q;

	logic [COL_W:0]   shifted;
	logic             qbit;
	logic [COL_W:0]   rem_next;

	always_comb begin
		shifted  = {rem_q[COL_W-1:0], quo_q[ACC_W-1]};
		qbit     = shifted >= {1'b0, dsr_q};
		rem_next = qbit ? shifted - {1'b0, dsr_q} : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.neg;
			dsr_q <= req.divisor;
			rem_q <= '0;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[ACC_W-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// ----- hw/rtl/flat_triangle_column_span_raster.sv -----
// top level: load and tick sequencer, span tables and output register
// depends on ftcs_pkg, ftcs_ram, ftcs_div
//
// A load beat (kind 0) whose three vertices all lie on screen busies the block for
// accept and table preset of columns left to right, then each non-vertical edge uses
// the shared divider and walks its columns, one table read and one table write per
// column, and each vertical edge is only stepped over. A load with a vertex off screen,
// and a tick with nothing pending, leave the block idle. A tick with a triangle pending
// takes the span table read, then the result into the output register, waiting while
// the output register is still full; the register holds it while the next input beat
// is taken. The span tables are never cleared: each load presets exactly the columns it
// later reads.
module flat_triangle_column_span_raster
	import ftcs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_item
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRESET,
		ST_EDGE,
		ST_DIV,
		ST_WALK_RD,
		ST_WALK_WR,
		ST_TICK
	} state_t;

	state_t                  state_q;
	logic                    pending_q;
	logic [COL_W-1:0]        left_q;
	logic [COL_W-1:0]        right_q;
	logic [COL_W-1:0]        cursor_q;
	logic [COLOR_W-1:0]      held_color_q;
	logic [COL_W-1:0]        vx_q [3];
	logic [ROW_W-1:0]        vy_q [3];
	logic [1:0]              edge_q;
	logic [COL_W-1:0]        wx_q;
	logic [COL_W-1:0]        xe_q;
	logic [ACC_W-1:0]        acc_q;
	logic signed [ACC_W:0]   step_q;
	logic                    out_valid_q;
	out_beat_t               out_item_q;

	logic                    in_fire;
	logic                    load_ok;
	logic [COL_W-1:0]        lx [3];
	logic [COL_W-1:0]        lo;
	logic [COL_W-1:0]        hi;
	logic [1:0]              edge_nx;
	logic [COL_W-1:0]        x0, x1, xs, xe;
	logic [ROW_W-1:0]        y0, y1, ys, ye;
	logic [ROW_W-1:0]        row;
	logic signed [ACC_W:0]   acc_sum;

	logic                    ram_we;
	logic [COL_W-1:0]        ram_waddr;
	logic [COL_W-1:0]        ram_raddr;
	logic [ROW_W-1:0]        top_wdata;
	logic signed [ROW_W:0]   bot_wdata;
	logic [ROW_W-1:0]        top_rd;
	logic [ROW_W:0]          bot_rd_raw;
	logic signed [ROW_W:0]   bot_rd;
	logic signed [ROW_W:0]   row_s;
	logic                    empty;
	logic                    out_load;
	out_beat_t               out_next;

	div_req_t                div_req;
	div_rsp_t                div_rsp;

	function automatic logic on_screen(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y);
		return !x[COORD_W-1] && (x[COORD_W-2:0] < (COORD_W-1)'(SCREEN_WIDTH)) &&
			!y[COORD_W-1] && (y[COORD_W-2:0] < (COORD_W-1)'(SCREEN_HEIGHT));
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		load_ok = on_screen(in_item.ax, in_item.ay) && on_screen(in_item.bx, in_item.by) &&
			on_screen(in_item.cx, in_item.cy);
		lx[0] = COL_W'(in_item.ax);
		lx[1] = COL_W'(in_item.bx);
		lx[2] = COL_W'(in_item.cx);
		lo = lx[0];
		hi = lx[0];
		if (lx[1] > hi) hi = lx[1];
		if (lx[2] > hi) hi = lx[2];
		if (lx[1] < lo) lo = lx[1];
		if (lx[2] < lo) lo = lx[2];
	end

	always_comb begin
		unique case (edge_q)
			2'd0:    edge_nx = 2'd1;
			2'd1:    edge_nx = 2'd2;
			default: edge_nx = 2'd0;
		endcase
		x0 = vx_q[edge_q];
		y0 = vy_q[edge_q];
		x1 = vx_q[edge_nx];
		y1 = vy_q[edge_nx];
		if (x0 < x1) begin
			xs = x0; ys = y0; xe = x1; ye = y1;
		end else begin
			xs = x1; ys = y1; xe = x0; ye = y0;
		end
		div_req.start    = (state_q == ST_EDGE) && (x0 != x1);
		div_req.neg      = ye < ys;
		div_req.dividend = {(ye < ys) ? ys - ye : ye - ys, FRAC_W'(0)};
		div_req.divisor  = xe - xs;
	end

	always_comb begin
		row        = acc_q[ACC_W-1:FRAC_W];
		row_s      = $signed({1'b0, row});
		bot_rd     = $signed(bot_rd_raw);
		acc_sum    = $signed({1'b0, acc_q}) + step_q;
		ram_we     = 1'b0;
		ram_waddr  = wx_q;
		ram_raddr  = (state_q == ST_WALK_RD) ? wx_q : cursor_q;
		top_wdata  = ROW_W'(SCREEN_HEIGHT);
		bot_wdata  = '1;
		unique case (state_q)
			ST_PRESET: begin
				ram_we = 1'b1;
			end
			ST_WALK_WR: begin
				ram_we    = 1'b1;
				top_wdata = (top_rd > row) ? row : top_rd;
				bot_wdata = (bot_rd < row_s) ? row_s : bot_rd;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		empty               = $signed({1'b0, top_rd}) > bot_rd;
		out_next.column     = OUT_COL_W'(cursor_q);
		out_next.top_row    = empty ? '0 : OUT_ROW_W'(top_rd);
		out_next.bottom_row = empty ? '0 : OUT_ROW_W'(bot_rd_raw[ROW_W-1:0]);
		out_next.fill_value = held_color_q;
		out_next.empty_res  = empty;
		out_next.last       = (cursor_q == right_q);
		out_load            = (state_q == ST_TICK) && (!out_valid_q || out_ready);
	end

	ftcs_ram #(.WIDTH(ROW_W), .DEPTH(SCREEN_WIDTH)) u_top_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (top_wdata),
		.raddr (ram_raddr),
		.rdata (top_rd)
	);

	ftcs_ram #(.WIDTH(ROW_W + 1), .DEPTH(SCREEN_WIDTH)) u_bot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (bot_wdata),
		.raddr (ram_raddr),
		.rdata (bot_rd_raw)
	);

	ftcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pending_q    <= 1'b0;
			left_q       <= '0;
			right_q      <= '0;
			cursor_q     <= '0;
			held_color_q <= '0;
			edge_q       <= '0;
			out_valid_q  <= 1'b0;
			out_item_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_item_q  <= out_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_item.kind == KIND_LOAD) begin
							pending_q <= 1'b0;
							if (load_ok) begin
								left_q       <= lo;
								right_q      <= hi;
								held_color_q <= in_item.color;
								edge_q       <= '0;
								state_q      <= ST_PRESET;
							end
						end else if (pending_q) begin
							state_q <= ST_TICK;
						end
					end
				end
				ST_PRESET: begin
					if (wx_q == right_q) begin
						state_q <= ST_EDGE;
					end
				end
				ST_EDGE: begin
					if (x0 != x1) begin
						state_q <= ST_DIV;
					end else if (edge_q == 2'd2) begin
						cursor_q  <= left_q;
						pending_q <= 1'b1;
						state_q   <= ST_IDLE;
					end else begin
						edge_q <= edge_nx;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_WALK_RD;
					end
				end
				ST_WALK_RD: begin
					state_q <= ST_WALK_WR;
				end
				ST_WALK_WR: begin
					if (wx_q != xe_q) begin
						state_q <= ST_WALK_RD;
					end else if (edge_q == 2'd2) begin
						cursor_q  <= left_q;
						pending_q <= 1'b1;
						state_q   <= ST_IDLE;
					end else begin
						edge_q  <= edge_nx;
						state_q <= ST_EDGE;
					end
				end
				ST_TICK: begin
					if (out_load) begin
						if (out_next.last) begin
							pending_q <= 1'b0;
						end else begin
							cursor_q <= cursor_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_item.kind == KIND_LOAD) begin
			vx_q[0] <= lx[0];
			vx_q[1] <= lx[1];
			vx_q[2] <= lx[2];
			vy_q[0] <= ROW_W'(in_item.ay);
			vy_q[1] <= ROW_W'(in_item.by);
			vy_q[2] <= ROW_W'(in_item.cy);
			wx_q    <= lo;
		end else if (state_q == ST_PRESET) begin
			wx_q <= wx_q + 1'b1;
		end else if (state_q == ST_EDGE) begin
			wx_q  <= xs;
			xe_q  <= xe;
			acc_q <= {ys, FRAC_W'(0)};
		end else if (state_q == ST_DIV && div_rsp.done) begin
			step_q <= div_rsp.quotient;
		end else if (state_q == ST_WALK_WR) begin
			wx_q  <= wx_q + 1'b1;
			acc_q <= acc_sum[ACC_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
